>>> sv/usb_control_request_decoder_core_assert.svh
// Assertion macros used by the control request decoder core.
// Plain text macros only; no other file dependencies.
`ifndef USB_CONTROL_REQUEST_DECODER_CORE_ASSERT_SVH
`define USB_CONTROL_REQUEST_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UCRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ucrd assertion failed: same-cycle check");

// Next-cycle implication, checked out of reset.
`define UCRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ucrd assertion failed: next-cycle check");

`endif

>>> sv/ucrd_pkg.sv
// Types and constants of the USB control request decoder.
// No dependencies; imported by every module of the block.
package ucrd_pkg;

    localparam logic [2:0] ST_CREATED    = 3'd0;
    localparam logic [2:0] ST_ATTACHED   = 3'd1;
    localparam logic [2:0] ST_POWERED    = 3'd2;
    localparam logic [2:0] ST_INIT       = 3'd3;
    localparam logic [2:0] ST_DEFAULT    = 3'd4;
    localparam logic [2:0] ST_ADDRESSED  = 3'd5;
    localparam logic [2:0] ST_CONFIGURED = 3'd6;
    localparam logic [2:0] ST_UNKNOWN    = 3'd7;

    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
    localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

    localparam logic [1:0] TYPE_STANDARD   = 2'd0;
    localparam logic [4:0] RCPT_ENDPOINT   = 5'd2;

    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_STRING = 8'd3;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_ADDRESS   = 2'd1;
    localparam logic [1:0] EV_CONFIG    = 2'd2;
    localparam logic [1:0] EV_INTERFACE = 2'd3;

    localparam int unsigned IN_BITS  = 72;
    localparam int unsigned OUT_BITS = 64;

    typedef struct packed {
        logic [2:0]  usb_state;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } req_t;

    typedef struct packed {
        logic        verdict;
        logic        reply_length;
        logic [7:0]  reply_byte;
        logic        descriptor_fetch;
        logic [7:0]  descriptor_kind;
        logic [7:0]  descriptor_number;
        logic [15:0] descriptor_limit;
        logic        halt_command;
        logic [6:0]  halt_endpoint;
        logic        halt_set;
        logic [1:0]  event_code;
        logic [6:0]  assigned_address;
    } res_t;

    typedef struct packed {
        logic [6:0]  dev_address;
        logic [6:0]  active_config;
        logic [15:0] active_interface;
        logic [15:0] active_alternate;
    } dev_state_t;

    typedef struct packed {
        logic        wr_address;
        logic [6:0]  address;
        logic        wr_config;
        logic [6:0]  config_value;
        logic        wr_interface;
        logic [15:0] interface_value;
        logic [15:0] alternate_value;
    } state_upd_t;

endpackage

>>> sv/usb_control_request_decoder_core.sv
// USB control request decoder for endpoint zero.
//
// Input channel (s_*): one decoded SETUP request per transfer, together
// with the device state it was received in. Output channel (m_*): one
// verdict record per request, in order: accept/stall, a one-byte reply for
// get configuration / get interface, a descriptor fetch command, an
// endpoint halt command, an event code and the current device address.
//
// The block holds the device address, active configuration, interface and
// alternate setting; set address, set configuration and set interface
// update them as the request passes from the input register to the result
// register, so the next request already sees the new values.
//
// An accepted request is captured in the input register, decoded, and its
// result is registered in the result register, which drives m_tdata.
// Throughput: one request per cycle while m_tready stays high, set by the
// single decode stage between the input register and the result register.
// Reset clears both stage valids and all held device state.
// When the receiver stalls, the result is held; one more request is taken
// into the input register, then s_tready drops until the result drains.
//
// Depends on ucrd_pkg, ucrd_decode, ucrd_state and the assertion header.
`include "usb_control_request_decoder_core_assert.svh"

module usb_control_request_decoder_core
    import ucrd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [2:0] usb_state, [10:3] request_type, [18:11] request_code,
    // [34:19] request_value, [50:35] request_index, [66:51] request_length,
    // [71:67] zero
    input  logic [IN_BITS-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] verdict, [1] reply_length, [9:2] reply_byte, [10] descriptor_fetch,
    // [18:11] descriptor_kind, [26:19] descriptor_number,
    // [42:27] descriptor_limit, [43] halt_command, [50:44] halt_endpoint,
    // [51] halt_set, [53:52] event_code, [60:54] assigned_address,
    // [63:61] zero
    output logic [OUT_BITS-1:0] m_tdata
);

    logic       in_valid_reg;
    logic       in_valid_next;
    req_t       req_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    res_t       res_reg;
    res_t       res_comb;
    state_upd_t upd;
    dev_state_t dev_state;
    logic       in_take;
    logic       out_load;

    // advance the decode stage whenever the result register is free or draining
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_take  = s_tvalid && s_tready;

    ucrd_decode u_decode (
        .req   (req_reg),
        .state (dev_state),
        .res   (res_comb),
        .upd   (upd)
    );

    ucrd_state u_state (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .upd   (upd),
        .state (dev_state)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: capture the request, hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.usb_state      <= s_tdata[2:0];
            req_reg.request_type   <= s_tdata[10:3];
            req_reg.request_code   <= s_tdata[18:11];
            req_reg.request_value  <= s_tdata[34:19];
            req_reg.request_index  <= s_tdata[50:35];
            req_reg.request_length <= s_tdata[66:51];
        end
        if (out_load)
        begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       res_reg.assigned_address,
                       res_reg.event_code,
                       res_reg.halt_set,
                       res_reg.halt_endpoint,
                       res_reg.halt_command,
                       res_reg.descriptor_limit,
                       res_reg.descriptor_number,
                       res_reg.descriptor_kind,
                       res_reg.descriptor_fetch,
                       res_reg.reply_byte,
                       res_reg.reply_length,
                       res_reg.verdict};

    // a stalled request never carries a command or an event
    `UCRD_ASSERT_NOW(a_stall_no_action, clk, rst_n,
        m_tvalid && res_reg.verdict,
        !res_reg.descriptor_fetch && !res_reg.halt_command && !res_reg.reply_length
        && (res_reg.event_code == EV_NONE))

    // at most one kind of action per result
    `UCRD_ASSERT_NOW(a_one_action, clk, rst_n,
        m_tvalid,
        $onehot0({res_reg.descriptor_fetch, res_reg.halt_command, res_reg.reply_length,
                  (res_reg.event_code != EV_NONE)}))

    // input side blocks only while both stages are full and the result is stuck
    `UCRD_ASSERT_NOW(a_ready_backpressure, clk, rst_n,
        !s_tready,
        in_valid_reg && out_valid_reg && !m_tready)

    // an assigned address lands in the state register from the request's wValue
    `UCRD_ASSERT_NEXT(a_address_stored, clk, rst_n,
        out_load && (res_comb.event_code == EV_ADDRESS),
        dev_state.dev_address == $past(req_reg.request_value[6:0]))

endmodule

>>> sv/ucrd_state.sv
// Device state registers: address, configuration, interface, alternate.
// Depends on ucrd_pkg.
module ucrd_state
    import ucrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  state_upd_t upd,
    output dev_state_t state
);

    dev_state_t state_reg;
    dev_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        if (load)
        begin
            if (upd.wr_address)
            begin
                state_next.dev_address = upd.address;
            end
            if (upd.wr_config)
            begin
                // a new configuration drops interface and alternate
                state_next.active_config    = upd.config_value;
                state_next.active_interface = '0;
                state_next.active_alternate = '0;
            end
            if (upd.wr_interface)
            begin
                state_next.active_interface = upd.interface_value;
                state_next.active_alternate = upd.alternate_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

>>> sv/ucrd_decode.sv
// Combinational decode of one standard request against the device state.
// Depends on ucrd_pkg.
module ucrd_decode
    import ucrd_pkg::*;
(
    input  req_t       req,
    input  dev_state_t state,
    output res_t       res,
    output state_upd_t upd
);

    logic       early;
    logic       allowed;
    logic       dir_in;
    logic [6:0] cfg_low;

    assign early   = (req.usb_state == ST_INIT) || (req.usb_state == ST_DEFAULT);
    assign allowed = !early || (req.request_code == REQ_SET_ADDRESS)
                     || (req.request_code == REQ_GET_DESCRIPTOR)
                     || (req.request_code == REQ_GET_CONFIGURATION);
    assign dir_in  = req.request_type[7];
    assign cfg_low = req.request_value[6:0];

    always_comb
    begin
        res = '0;
        res.verdict = 1'b1;
        upd = '0;
        upd.address         = req.request_value[6:0];
        upd.config_value    = (cfg_low != 7'd0) ? (cfg_low - 7'd1) : 7'd0;
        upd.interface_value = req.request_index;
        upd.alternate_value = req.request_value;

        priority if (req.request_type[6:5] != TYPE_STANDARD)
        begin
            res.verdict = 1'b0;
        end
        else if ((req.usb_state == ST_CREATED) || (req.usb_state == ST_ATTACHED)
                 || (req.usb_state == ST_POWERED) || (req.usb_state == ST_UNKNOWN))
        begin
            res.verdict = 1'b1;
        end
        else if (allowed)
        begin
            if (dir_in)
            begin
                priority if (req.request_code == REQ_GET_STATUS)
                begin
                    res.verdict = 1'b0;
                end
                else if (req.request_code == REQ_GET_DESCRIPTOR)
                begin
                    if ((req.request_value[15:8] >= DESC_DEVICE)
                        && (req.request_value[15:8] <= DESC_STRING))
                    begin
                        res.verdict           = 1'b0;
                        res.descriptor_fetch  = 1'b1;
                        res.descriptor_kind   = req.request_value[15:8];
                        res.descriptor_number = req.request_value[7:0];
                        res.descriptor_limit  = req.request_length;
                    end
                end
                else if (req.request_code == REQ_GET_CONFIGURATION)
                begin
                    res.verdict      = 1'b0;
                    res.reply_length = 1'b1;
                    res.reply_byte   = {1'b0, state.active_config};
                end
                else if (req.request_code == REQ_GET_INTERFACE)
                begin
                    res.verdict      = 1'b0;
                    res.reply_length = 1'b1;
                    res.reply_byte   = state.active_interface[7:0];
                end
                else
                begin
                    // misdirected or unsupported code: keep the stall
                    res.verdict = 1'b1;
                end
            end
            else
            begin
                priority if ((req.request_code == REQ_CLEAR_FEATURE)
                             || (req.request_code == REQ_SET_FEATURE))
                begin
                    if (req.request_type[4:0] == RCPT_ENDPOINT)
                    begin
                        res.verdict       = 1'b0;
                        res.halt_command  = 1'b1;
                        res.halt_endpoint = req.request_index[6:0];
                        res.halt_set      = (req.request_code == REQ_SET_FEATURE);
                    end
                end
                else if (req.request_code == REQ_SET_ADDRESS)
                begin
                    if ((req.usb_state == ST_DEFAULT) && (req.request_value[15:7] == 9'd0))
                    begin
                        res.verdict    = 1'b0;
                        res.event_code = EV_ADDRESS;
                        upd.wr_address = 1'b1;
                    end
                end
                else if (req.request_code == REQ_SET_CONFIGURATION)
                begin
                    res.verdict    = 1'b0;
                    res.event_code = EV_CONFIG;
                    upd.wr_config  = 1'b1;
                end
                else if (req.request_code == REQ_SET_INTERFACE)
                begin
                    res.verdict      = 1'b0;
                    res.event_code   = EV_INTERFACE;
                    upd.wr_interface = 1'b1;
                end
                else
                begin
                    // misdirected or unsupported code: keep the stall
                    res.verdict = 1'b1;
                end
            end
        end
        else
        begin
            // code not allowed in an early state: keep the stall
            res.verdict = 1'b1;
        end

        // report the address as it stands after this request
        res.assigned_address = upd.wr_address ? upd.address : state.dev_address;
    end

endmodule
